/* hdl/mbd_pkg.sv */
// Package for the mipmap box downsampler: register map, shared widths and
// the position/control word passed from the position tracker to the datapath.
// No dependencies.
package mbd_pkg;

  localparam int MBD_MAX_WIDTH_LOG2 = 12;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register word indexes (byte address = 4 * index).
  localparam logic [1:0] REG_WIDTH_LOG2  = 2'd0;
  localparam logic [1:0] REG_HEIGHT_LOG2 = 2'd1;
  localparam logic [1:0] REG_HAS_ALPHA   = 2'd2;

  localparam logic [3:0] RST_WIDTH_LOG2  = 4'd1;
  localparam logic [3:0] RST_HEIGHT_LOG2 = 4'd1;
  localparam logic       RST_HAS_ALPHA   = 1'b1;

  localparam int PIX_W  = 32;
  localparam int PAIR_W = 36;

  typedef struct packed {
    logic hold;    // store this pixel as the left half of a pair
    logic emit;    // this pixel completes a destination pixel
    logic two_d;   // 2x2 averaging mode
    logic wr_en;   // write the pair sum to the line store
    logic rd_en;   // read the pair sum of the row above
    logic last;    // last source pixel of the level
  } pos_info_t;

endpackage

/* hdl/mipmap_box_downsampler.sv */
// Mipmap 2x2 box downsampler.
// Source pixels arrive on the in_ stream in raster order, one word per
// pixel (red in bits 7:0 up to alpha in bits 31:24). Each destination pixel
// leaves on the out_ stream with the same packing; out_tlast marks the last
// destination pixel of a level. Levels of at least 2x2 average each 2x2
// block; a level one pixel wide or tall averages pairs along its long axis;
// a 1x1 level consumes its pixel and produces nothing. After the last source
// pixel the next words start a new level of the same size.
// The cfg_ APB port sets width_log2, height_log2 and has_alpha; a write to
// them restarts the position counters. Write it only while the block is idle.
// Throughput is one input word per cycle while the receiver does not stall.
// The word completing a result is registered first in the stage that waits for
// the line store read, then in the output register. The line store has one
// write port and one read port.
// When the receiver stalls, the output register holds, one further completing
// word can wait in the middle stage, and in_tready drops after that.
// Synchronous reset clears the counters, the valid flags and the registers
// (to their reset values). The line store is not cleared; an odd row only
// reads entries written by the even row above it.
module mipmap_box_downsampler
  import mbd_pkg::*;
#(
  parameter int MAX_WIDTH_LOG2 = MBD_MAX_WIDTH_LOG2
) (
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,
  // out_tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [PIX_W-1:0]  out_tdata,
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int LINE_AW = (MAX_WIDTH_LOG2 > 1) ? MAX_WIDTH_LOG2 - 1 : 1;

  logic [3:0]          width_log2_r;
  logic [3:0]          height_log2_r;
  logic                has_alpha_r;
  logic                cfg_wr;
  logic                cfg_hit;
  logic [1:0]          cfg_idx;

  logic                accept;
  pos_info_t           info;
  logic [PAIR_W-1:0]   pair_sum;
  logic [LINE_AW-1:0]  line_idx;
  logic [PAIR_W-1:0]   above_sum;

  logic                s1_valid_r;
  logic                s1_two_d_r;
  logic                s1_last_r;
  logic [PAIR_W-1:0]   s1_pair_r;
  logic                out_free;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_hit    = (cfg_idx == REG_WIDTH_LOG2) || (cfg_idx == REG_HEIGHT_LOG2) ||
                      (cfg_idx == REG_HAS_ALPHA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_log2_r  <= RST_WIDTH_LOG2;
      height_log2_r <= RST_HEIGHT_LOG2;
      has_alpha_r   <= RST_HAS_ALPHA;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH_LOG2:  width_log2_r  <= cfg_pwdata[3:0];
        REG_HEIGHT_LOG2: height_log2_r <= cfg_pwdata[3:0];
        REG_HAS_ALPHA:   has_alpha_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH_LOG2:  cfg_prdata = {{(CFG_DW-4){1'b0}}, width_log2_r};
      REG_HEIGHT_LOG2: cfg_prdata = {{(CFG_DW-4){1'b0}}, height_log2_r};
      REG_HAS_ALPHA:   cfg_prdata = {{(CFG_DW-1){1'b0}}, has_alpha_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Only completing words occupy the middle stage.
  assign in_tready = !s1_valid_r || out_free;
  assign accept    = in_tvalid && in_tready;

  mbd_pos_ctrl #(
    .MAX_WIDTH_LOG2 (MAX_WIDTH_LOG2),
    .LINE_AW        (LINE_AW)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cnt_clr     (cfg_wr && cfg_hit),
    .width_log2  (width_log2_r),
    .height_log2 (height_log2_r),
    .pixel       (in_tdata),
    .info        (info),
    .pair_sum    (pair_sum),
    .line_idx    (line_idx)
  );

  mbd_line_ram #(
    .AW (LINE_AW)
  ) u_line (
    .clk   (clk),
    .we    (accept && info.wr_en),
    .waddr (line_idx),
    .wdata (pair_sum),
    .re    (accept && info.rd_en),
    .raddr (line_idx),
    .rdata (above_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= info.emit;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_two_d_r <= info.two_d;
      s1_last_r  <= info.last;
      s1_pair_r  <= pair_sum;
    end
  end

  mbd_avg u_avg (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_valid  (s1_valid_r),
    .two_d      (s1_two_d_r),
    .last       (s1_last_r),
    .has_alpha  (has_alpha_r),
    .pair_sum   (s1_pair_r),
    .above_sum  (above_sum),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* hdl/mbd_line_ram.sv */
// Line store for the horizontal pair sums of an even source row.
// One write port and one read port with registered read data. Uses mbd_pkg.
module mbd_line_ram
  import mbd_pkg::*;
#(
  parameter int AW = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [PAIR_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [PAIR_W-1:0] rdata
);

  logic [PAIR_W-1:0] mem [2**AW];
  logic [PAIR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/mbd_pos_ctrl.sv */
// Position tracker: column/row counters, the held left pixel and the
// horizontal pair sums. Decides per word what the datapath does. Uses mbd_pkg.
module mbd_pos_ctrl
  import mbd_pkg::*;
#(
  parameter int MAX_WIDTH_LOG2 = MBD_MAX_WIDTH_LOG2,
  parameter int LINE_AW        = MAX_WIDTH_LOG2 - 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               cnt_clr,
  input  logic [3:0]         width_log2,
  input  logic [3:0]         height_log2,
  input  logic [PIX_W-1:0]   pixel,
  output pos_info_t          info,
  output logic [PAIR_W-1:0]  pair_sum,
  output logic [LINE_AW-1:0] line_idx
);

  localparam int CW = MAX_WIDTH_LOG2;
  localparam logic [3:0] MAX_L2 = 4'(MAX_WIDTH_LOG2);

  logic [CW-1:0]    col_r, col_nxt;
  logic [CW-1:0]    row_r, row_nxt;
  logic [PIX_W-1:0] held_r;
  logic [3:0]       wl, hl;
  logic [CW-1:0]    col_max, row_max;
  logic             last_col, last_row;
  logic             single, one_d, pos_odd;

  assign wl = (width_log2  > MAX_L2) ? MAX_L2 : width_log2;
  assign hl = (height_log2 > MAX_L2) ? MAX_L2 : height_log2;

  assign col_max  = ~({CW{1'b1}} << wl);
  assign row_max  = ~({CW{1'b1}} << hl);
  assign last_col = (col_r == col_max);
  assign last_row = (row_r == row_max);

  assign single  = (wl == 4'd0) && (hl == 4'd0);
  assign one_d   = !single && ((wl == 4'd0) || (hl == 4'd0));
  assign pos_odd = (wl == 4'd0) ? row_r[0] : col_r[0];

  always_comb begin
    info.two_d = !single && !one_d;
    info.hold  = one_d ? !pos_odd : (info.two_d && !col_r[0]);
    info.emit  = one_d ? pos_odd : (info.two_d && col_r[0] && row_r[0]);
    info.wr_en = info.two_d && col_r[0] && !row_r[0];
    info.rd_en = info.two_d && col_r[0] && row_r[0];
    info.last  = last_col && last_row;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pair_sum[9*k +: 9] = {1'b0, held_r[8*k +: 8]} + {1'b0, pixel[8*k +: 8]};
    end
  end

  assign line_idx = LINE_AW'(col_r >> 1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cnt_clr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept && info.hold) begin
        held_r <= pixel;
      end
    end
  end

endmodule

/* hdl/mbd_avg.sv */
// Averaging datapath and output register: combines the pair sum with the
// pair sum from the line above (2x2) or halves it (1-D). Uses mbd_pkg.
module mbd_avg
  import mbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              src_valid,
  input  logic              two_d,
  input  logic              last,
  input  logic              has_alpha,
  input  logic [PAIR_W-1:0] pair_sum,
  input  logic [PAIR_W-1:0] above_sum,
  output logic              out_free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [PIX_W-1:0]  out_tdata,
  output logic              out_tlast
);

  logic             valid_r;
  logic [PIX_W-1:0] data_r;
  logic             last_r;
  logic [PIX_W-1:0] avg;
  logic [9:0]       quad;

  always_comb begin
    quad = '0;
    for (int k = 0; k < 4; k++) begin
      quad = {1'b0, above_sum[9*k +: 9]} + {1'b0, pair_sum[9*k +: 9]};
      avg[8*k +: 8] = two_d ? quad[9:2] : pair_sum[9*k+1 +: 8];
    end
    if (!has_alpha) begin
      avg[31:24] = 8'd0;
    end
  end

  assign out_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && src_valid) begin
      data_r <= avg;
      last_r <= last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

/* hdl/mbd_checker.sv */
// Port-level checks for the mipmap box downsampler, bound to the top level.
// Depends on mbd_pkg and mipmap_box_downsampler.
module mbd_checker
  import mbd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [PIX_W-1:0]  out_tdata,
  input logic              out_tlast
);

  // A stalled output word keeps its valid flag.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // A stalled output word keeps its data and last flag.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // With the output register empty the middle stage can always drain, so
  // the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output is empty");

endmodule

bind mipmap_box_downsampler mbd_checker u_mbd_checker (.*);
